// ----- rtl/modal_integrator_with_rms_top_macros.svh -----
// Assertion macros for the modal integrator with RMS block.
`ifndef MODAL_INTEGRATOR_WITH_RMS_TOP_MACROS_SVH
`define MODAL_INTEGRATOR_WITH_RMS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MIRMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MIRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mirms_pkg.sv -----
// ----------------------------------------------------------------------------
// mirms_pkg
// Shared widths, constants, types and saturation helper for the modal
// integrator with RMS block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mirms_pkg;

  // Number of modes per frame; a power of two so the frame mean is a shift.
  localparam int NUM_MODES  = 32;
  localparam int MODE_W     = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int MODE_SHIFT = $clog2(NUM_MODES);

  localparam int COEFF_W = 16;
  localparam int GAIN_W  = 16;
  localparam int DATA_W  = 24;
  localparam int MIDX_W  = 10;
  localparam int RMS_W   = 23;
  localparam int SUM_W   = 58;
  localparam int SQ_W    = 2 * DATA_W;
  localparam int PROD_W  = GAIN_W + 1 + DATA_W;
  localparam int WIDE_W  = PROD_W + 1;
  localparam int RAD_W   = 48;
  localparam int ROOT_W  = RAD_W / 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
  localparam logic [MODE_W-1:0] LAST_MODE  = MODE_W'(NUM_MODES - 1);

  localparam logic signed [WIDE_W-1:0] S24_MAX = WIDE_W'(64'sd8388607);
  localparam logic signed [WIDE_W-1:0] S24_MIN = WIDE_W'(-64'sd8388608);

  typedef struct packed {
    logic              en;
    logic [MODE_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } corr_wr_t;

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S24_MAX) begin
      r = S24_MAX[DATA_W-1:0];
    end else if (v < S24_MIN) begin
      r = S24_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/mirms_ram.sv -----
// ----------------------------------------------------------------------------
// mirms_ram
// Per-mode correction store: one write and one registered read per cycle,
// with a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mirms_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [mirms_pkg::MODE_W-1:0]  rd_addr,
  output logic [mirms_pkg::DATA_W-1:0]  rd_data,
  input  mirms_pkg::corr_wr_t           wr
);

  logic [mirms_pkg::DATA_W-1:0]    mem [mirms_pkg::NUM_MODES];
  logic [mirms_pkg::NUM_MODES-1:0] vld_r;
  logic [mirms_pkg::DATA_W-1:0]    rd_data_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Entries not yet written since reset read as zero.
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- rtl/mirms_sqrt.sv -----
// ----------------------------------------------------------------------------
// mirms_sqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mirms_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mirms_pkg::RAD_W-1:0]   radicand,
  output logic                          busy,
  output logic                          done,
  output logic [mirms_pkg::ROOT_W-1:0]  root
);

  localparam int REM_W = mirms_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(mirms_pkg::ROOT_W);

  logic [mirms_pkg::RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]             rem_r;
  logic [mirms_pkg::ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  assign rem_sh = {rem_r, rad_r[mirms_pkg::RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(mirms_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[mirms_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[mirms_pkg::ROOT_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/modal_integrator_with_rms_top.sv -----
// ----------------------------------------------------------------------------
// modal_integrator_with_rms_top
// Modal integral controller: per-mode integrator with frame RMS of residual.
// ----------------------------------------------------------------------------
// One item is in flight at a time. After its input transfer, an ordinary mode
// passes through store read and residual, multiply, step, write-back and output
// load into the output register. The next input can transfer in the cycle after
// the output load. The last mode of a frame adds 24 square-root iterations and
// a hand-over step before its output load. The input stalls while an item is
// being worked. The output register holds a finished result, so the input side
// is free again while the sink stalls. A stalled sink with a result still
// waiting delays the output load for as long as it stalls. The correction
// store is a 32-entry memory with valid bits cleared at reset, so no clearing
// pass is needed.
`timescale 1ns / 1ps

module modal_integrator_with_rms_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mirms_pkg::GAIN_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mirms_pkg::COEFF_W-1:0] in_coeff,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mirms_pkg::DATA_W-1:0] out_step_out,
  output logic [mirms_pkg::MIDX_W-1:0]      out_mode_index,
  output logic [mirms_pkg::RMS_W-1:0]       out_rms_residual,
  output logic                              out_frame_end
);

  localparam int DW = mirms_pkg::DATA_W;
  localparam int WW = mirms_pkg::WIDE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RES  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [mirms_pkg::GAIN_W-1:0]         gain_r;
  logic [mirms_pkg::MODE_W-1:0]         mode_cnt_r;
  logic [mirms_pkg::MODE_W-1:0]         mode_r;
  logic                                 last_r;
  logic signed [mirms_pkg::COEFF_W-1:0] coeff_r;
  logic signed [DW-1:0]                 corr_r;
  logic signed [DW-1:0]                 resid_r;
  logic signed [mirms_pkg::PROD_W-1:0]  prod_r;
  logic [mirms_pkg::SQ_W-1:0]           sq_r;
  logic signed [DW-1:0]                 step_r;
  logic [mirms_pkg::SUM_W-1:0]          total_r;
  logic [mirms_pkg::SUM_W-1:0]          sum_r;
  logic [mirms_pkg::RMS_W-1:0]          rms_r;

  logic                                 out_valid_r;
  logic signed [DW-1:0]                 out_step_r;
  logic [mirms_pkg::MIDX_W-1:0]         out_mode_r;
  logic [mirms_pkg::RMS_W-1:0]          out_rms_r;
  logic                                 out_end_r;

  logic                                 in_xfer;
  logic                                 out_xfer;
  logic                                 out_load;
  logic [DW-1:0]                        corr_rd;
  mirms_pkg::corr_wr_t                  corr_wr;

  logic signed [WW-1:0]                 resid_sum;
  logic signed [WW-1:0]                 neg_prod;
  logic signed [WW-1:0]                 step_wide;
  logic signed [WW-1:0]                 acc_sum;

  logic                                 sqrt_start;
  logic                                 sqrt_busy;
  logic                                 sqrt_done;
  logic [mirms_pkg::ROOT_W-1:0]         sqrt_root;
  logic [mirms_pkg::RAD_W-1:0]          mean_sq;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  mirms_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (mode_cnt_r),
    .rd_data (corr_rd),
    .wr      (corr_wr)
  );

  // Residual: coefficient plus stored correction, clamped.
  assign resid_sum = {{(WW - mirms_pkg::COEFF_W){coeff_r[mirms_pkg::COEFF_W-1]}}, coeff_r}
                   + {{(WW - DW){corr_rd[DW-1]}}, corr_rd};

  // Step: floor(-(gain * residual) / 2^15), clamped.
  assign neg_prod  = -{prod_r[mirms_pkg::PROD_W-1], prod_r};
  assign step_wide = neg_prod >>> 15;

  assign acc_sum = {{(WW - DW){corr_r[DW-1]}}, corr_r}
                 + {{(WW - DW){step_r[DW-1]}}, step_r};

  assign corr_wr.en   = (state_r == S_WB);
  assign corr_wr.addr = mode_r;
  assign corr_wr.data = mirms_pkg::sat24(acc_sum);

  assign sqrt_start = (state_r == S_WB) && last_r;
  assign mean_sq    = mirms_pkg::RAD_W'(total_r >> mirms_pkg::MODE_SHIFT);

  mirms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (mean_sq),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_RES;
      end
      S_RES:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_STEP;
      S_STEP: state_nxt = S_WB;
      S_WB:   state_nxt = last_r ? S_SQRT : S_OUT;
      S_SQRT: begin
        if (sqrt_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= mirms_pkg::GAIN_RESET;
      mode_cnt_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (in_xfer) begin
        mode_cnt_r <= (mode_cnt_r == mirms_pkg::LAST_MODE) ? '0 : mode_cnt_r + 1'b1;
      end
      // Restart the frame sum after the last mode.
      if (state_r == S_WB) begin
        sum_r <= last_r ? '0 : total_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      coeff_r <= in_coeff;
      mode_r  <= mode_cnt_r;
      last_r  <= (mode_cnt_r == mirms_pkg::LAST_MODE);
    end
    if (state_r == S_RES) begin
      corr_r  <= corr_rd;
      resid_r <= mirms_pkg::sat24(resid_sum);
    end
    if (state_r == S_MUL) begin
      prod_r <= $signed({1'b0, gain_r}) * resid_r;
      sq_r   <= resid_r * resid_r;
    end
    if (state_r == S_STEP) begin
      step_r  <= mirms_pkg::sat24(step_wide);
      total_r <= sum_r + {{(mirms_pkg::SUM_W - mirms_pkg::SQ_W){1'b0}}, sq_r};
    end
    if (state_r == S_WB) begin
      rms_r <= '0;
    end else if (sqrt_done) begin
      // Clamp the one root that overflows 23 bits.
      rms_r <= sqrt_root[mirms_pkg::ROOT_W-1:mirms_pkg::RMS_W] != '0 ? '1
             : sqrt_root[mirms_pkg::RMS_W-1:0];
    end
    if (out_load) begin
      out_step_r <= step_r;
      out_mode_r <= {{(mirms_pkg::MIDX_W - mirms_pkg::MODE_W){1'b0}}, mode_r};
      out_rms_r  <= rms_r;
      out_end_r  <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_out     = out_step_r;
  assign out_mode_index   = out_mode_r;
  assign out_rms_residual = out_rms_r;
  assign out_frame_end    = out_end_r;

`include "modal_integrator_with_rms_top_macros.svh"

  `MIRMS_ASSERT_NEXT(a_one_in_flight, in_xfer, in_stall, "input taken while an item is in flight")
  `MIRMS_ASSERT_NOW(a_end_on_last, out_valid && out_frame_end, out_mode_index == mirms_pkg::MIDX_W'(mirms_pkg::NUM_MODES - 1), "frame end on wrong mode")
  `MIRMS_ASSERT_NOW(a_rms_zero, out_valid && !out_frame_end, out_rms_residual == '0, "rms set outside frame end")
  `MIRMS_ASSERT_NOW(a_sqrt_idle, sqrt_start, !sqrt_busy, "square root restarted while busy")

endmodule

// ----- tb/modal_integrator_with_rms_top_tb.sv -----
// ----------------------------------------------------------------------------
// modal_integrator_with_rms_top_tb
// Self-checking bench for the modal integrator: a short table of probes, then
// random coefficient streams under several loop gains and an alternating
// drive that builds up large stored corrections. Every result is compared field
// by field with its pinned probe row or an in-bench integrator that tracks the
// stored corrections, the mode count and the frame sum of squared residuals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modal_integrator_with_rms_top_tb;

  import mirms_pkg::*;

  localparam longint S24_TOP    = 64'sd8388607;
  localparam longint S24_BOTTOM = -64'sd8388608;
  localparam longint RMS_TOP    = 64'sd8388607;

  localparam int PROBE_ROWS   = 24;
  localparam int PROBE_PINNED = 6;
  localparam int DRIVE_FRAMES = 18;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_CAP    = 40;
  localparam int RUN_LIMIT     = 1000000;

  // Probe coefficients; the first PROBE_PINNED rows have their step typed in.
  localparam logic [COEFF_W-1:0] PROBE_COEFF [PROBE_ROWS] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h4000,
    16'hC000, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h7FFF,
    16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000, 16'hEFFF,
    16'h3039, 16'hCFC7, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000
  };
  // Gain 0.5 from reset on an empty store: step = floor(-coeff / 2).
  localparam logic [DATA_W-1:0] PROBE_STEP [PROBE_PINNED] = '{
    24'd0, -24'sd16384, 24'd16384, -24'sd1, 24'd0, -24'sd8192
  };

  typedef struct packed {
    logic [DATA_W-1:0] step;
    logic [MIDX_W-1:0] mode;
    logic [RMS_W-1:0]  rms;
    logic              fe;
  } mode_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_HEAVY} rx_mode_e;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [GAIN_W-1:0]         cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [COEFF_W-1:0] in_coeff  = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_step_out;
  logic [MIDX_W-1:0]         out_mode_index;
  logic [RMS_W-1:0]          out_rms_residual;
  logic                      out_frame_end;

  // Integrator shadow state
  logic signed [DATA_W-1:0] corr_shadow [NUM_MODES];
  int                       mode_ctr;
  logic [SUM_W-1:0]         sq_total;
  logic [GAIN_W-1:0]        loop_gain_q;

  mode_result_t due_q [$];
  mode_result_t pinned_q [$];
  int           fault_count = 0;
  int           burst_left  = 0;
  int           cycle_count = 0;
  rx_mode_e     rx_mode     = RX_FREE;
  int           rx_span     = 0;

  modal_integrator_with_rms_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_coeff         (in_coeff),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_step_out     (out_step_out),
    .out_mode_index   (out_mode_index),
    .out_rms_residual (out_rms_residual),
    .out_frame_end    (out_frame_end)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint clamp_s24(input longint v);
    if (v > S24_TOP) begin
      return S24_TOP;
    end
    if (v < S24_BOTTOM) begin
      return S24_BOTTOM;
    end
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) begin
        r = t;
      end
    end
    return r;
  endfunction

  // Advance the shadow integrator by one mode and return its result.
  function automatic mode_result_t integrate_mode(input logic signed [COEFF_W-1:0] c);
    mode_result_t   r;
    longint         held;
    longint         resid;
    longint         gain_l;
    longint         step;
    longint unsigned root;
    held   = corr_shadow[mode_ctr];
    gain_l = loop_gain_q;
    resid  = clamp_s24(longint'(c) + held);
    // arithmetic shift floors towards minus infinity
    step   = clamp_s24((-(gain_l * resid)) >>> 15);
    corr_shadow[mode_ctr] = DATA_W'(clamp_s24(held + step));
    sq_total = sq_total + SUM_W'(resid * resid);
    r.step = DATA_W'(step);
    r.mode = MIDX_W'(mode_ctr);
    r.rms  = '0;
    r.fe   = 1'b0;
    if (mode_ctr == NUM_MODES - 1) begin
      root = root_floor(64'(sq_total) / NUM_MODES);
      if (root > RMS_TOP) begin
        root = RMS_TOP;
      end
      r.rms    = RMS_W'(root);
      r.fe     = 1'b1;
      sq_total = '0;
      mode_ctr = 0;
    end else begin
      mode_ctr = mode_ctr + 1;
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      fault_count++;
      // keep the log short on a badly broken block
      if (fault_count <= REPORT_CAP) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin : scoreboard
    mode_result_t got;
    mode_result_t want;
    mode_result_t fresh;
    if (!rst_n) begin
      foreach (corr_shadow[i]) begin
        corr_shadow[i] = '0;
      end
      mode_ctr    = 0;
      sq_total    = '0;
      loop_gain_q = GAIN_RESET;
    end else begin
      if (cfg_we) begin
        loop_gain_q = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        got = {out_step_out, out_mode_index, out_rms_residual, out_frame_end};
        if (due_q.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_CAP) begin
            $display("%0t: unexpected result: expected none, got step %0d mode %0d",
                     $time, $signed(got.step), got.mode);
          end
        end else begin
          want = due_q.pop_front();
          check_field("step_out", $signed(want.step), $signed(got.step));
          check_field("mode_index", want.mode, got.mode);
          check_field("rms_residual", want.rms, got.rms);
          check_field("frame_end", want.fe, got.fe);
        end
      end
      if (in_valid && !in_stall) begin
        fresh = integrate_mode(in_coeff);
        if (pinned_q.size() != 0) begin
          fresh = pinned_q.pop_front();
        end
        due_q.push_back(fresh);
      end
    end
  end

  // Sink back-pressure: free, choppy and heavy spells of random length.
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_span <= $urandom_range(16, 160);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_FREE: begin
        out_stall <= 1'b0;
      end
      RX_CHOPPY: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("** modal_integrator_with_rms_top: FAILED **");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_coeff(input logic signed [COEFF_W-1:0] c);
    int gap;
    in_valid <= 1'b1;
    in_coeff <= c;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Write the gain only once every result has drained.
  task automatic set_gain(input logic [GAIN_W-1:0] g);
    in_valid <= 1'b0;
    while (due_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: begin
        return 16'h7FFF;
      end
      1: begin
        return 16'h8000;
      end
      2: begin
        return COEFF_W'(int'($urandom_range(0, 8)) - 4);
      end
      3: begin
        return COEFF_W'(int'($urandom_range(0, 2047)) - 1024);
      end
      default: begin
        return COEFF_W'($urandom);
      end
    endcase
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_coeff(pick_coeff());
    end
  endtask

  initial begin : stimulus
    logic signed [COEFF_W-1:0] c;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < PROBE_ROWS; k++) begin
      if (k < PROBE_PINNED) begin
        pinned_q.push_back({PROBE_STEP[k], MIDX_W'(k), {RMS_W{1'b0}}, 1'b0});
      end
      send_coeff(PROBE_COEFF[k]);
    end

    run_random(150);
    set_gain(16'd0);
    run_random(100);
    set_gain(16'hFFFF);
    run_random(150);
    set_gain(16'd32768);
    run_random(100);
    repeat (4) begin
      set_gain(GAIN_W'($urandom_range(1, 65534)));
      run_random(80);
    end
    set_gain(16'd1);
    run_random(80);

    // Gain just under two with the sign flipping every frame grows each
    // mode's stored correction by about twice the coefficient per frame.
    set_gain(16'hFFFF);
    for (int f = 0; f < DRIVE_FRAMES; f++) begin
      for (int k = 0; k < NUM_MODES; k++) begin
        c = f[0] ? COEFF_W'(-32768 + int'($urandom_range(0, 63)))
                 : COEFF_W'(32767 - int'($urandom_range(0, 63)));
        send_coeff(c);
      end
    end

    in_valid <= 1'b0;
    while (due_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("** modal_integrator_with_rms_top: PASSED **");
    end else begin
      $display("** modal_integrator_with_rms_top: FAILED **");
    end
    $finish;
  end

endmodule
